>>> rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants for the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MaxKernel = 7;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int LineRows  = (MaxKernel > 1) ? MaxKernel - 1 : 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int SlotW     = (LineRows > 1) ? $clog2(LineRows) : 1;
  localparam int MemAw     = SlotW + ColW;
  localparam int MemDepth  = LineRows * MaxWidth;
  localparam int KW        = 3;
  localparam int CsumW     = 11;
  localparam int WsumW     = 14;
  localparam int DivW      = 6;
  localparam int PixW      = 24;

  localparam logic [1:0] RegKernel = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_ACC, S_WR, S_SUM, S_CHK, S_DIV, S_OUT
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

>>> rtl/box_mean_filter_rgb.sv
// ----------------------------------------------------------------------------
// box_mean_filter_rgb
// K x K box mean filter over a raster stream of three-channel pixels.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one pixel per beat in raster
// order. Output channel: out_valid_o / out_stall_i carry one filtered pixel
// with its centre position; frame_end_o marks the last one of a frame.
// Border pixels produce no output beat.
// One pixel is handled at a time. For each one the block reads the stored
// rows of its column one by one over the single read port of the line
// store, sums the column sums of the kernel and, if the pixel gives a
// result, runs the 14-step divider before it takes the next pixel.
// The output register holds a result while out_stall_i is high; the block
// then waits with its next result until that beat is taken.
// Reset clears the counters and sets K = 5, 640 x 480. The line store is not
// cleared; each entry read for a result was written earlier in the frame.
// A register write over the APB port restarts the frame.
// ----------------------------------------------------------------------------
module box_mean_filter_rgb
  import bmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  chan_a_i,
  input  logic [7:0]  chan_b_i,
  input  logic [7:0]  chan_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  mean_a_o,
  output logic [7:0]  mean_b_o,
  output logic [7:0]  mean_c_o,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic        frame_end_o
);

  seq_state_e state_q, state_d;

  logic [KW-1:0]   kernel_q;
  logic [10:0]     width_q, height_q;
  logic [ColW-1:0] r_q, c_q, cur_r_q, cur_c_q;
  logic [SlotW-1:0] slot_q, cur_slot_q, rd_slot_q;
  logic [PixW-1:0] pix_q;
  logic [KW-1:0]   cnt_q, idx_q;
  logic [2:0][CsumW-1:0] acc_q;
  logic [MaxKernel-1:0][2:0][CsumW-1:0] col_q;
  logic [2:0][WsumW-1:0] wsum_q;
  logic [9:0]      res_row_q, res_col_q;
  logic            res_end_q;
  logic            out_valid_q;
  logic [2:0][7:0] mean_q;

  // effective configuration
  logic [KW-1:0]   k_eff, h_eff;
  logic [10:0]     w_eff, ht_eff;
  logic [11:0]     r_lim, c_lim;
  logic            in_acc, cfg_wr, res_ok;
  logic            out_free;
  logic [SlotW-1:0] slot_m1;
  logic [PixW-1:0] mem_rdata;
  logic            mem_re, mem_we;
  div_ctrl_t       div_ctrl;
  logic [2:0][7:0] quot;
  logic [DivW-1:0] den;

  assign k_eff  = (kernel_q == '0) ? KW'(1) : kernel_q;
  assign h_eff  = k_eff >> 1;
  assign w_eff  = (width_q == '0) ? 11'd1 :
                  ((width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q);
  assign ht_eff = (height_q == '0) ? 11'd1 :
                  ((height_q > 11'(MaxHeight)) ? 11'(MaxHeight) : height_q);
  assign r_lim  = 12'(ht_eff) + 12'(k_eff) - 12'd1 - {8'd0, h_eff, 1'b0};
  assign c_lim  = 12'(w_eff) + 12'(k_eff) - 12'd1 - {8'd0, h_eff, 1'b0};
  assign den    = DivW'(k_eff) * DivW'(k_eff);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign slot_m1    = (rd_slot_q == '0) ? SlotW'(LineRows - 1) : rd_slot_q - 1'b1;

  assign res_ok = (12'(cur_r_q) >= 12'(k_eff) - 12'd1) && (12'(cur_r_q) < r_lim) &&
                  (12'(cur_c_q) >= 12'(k_eff) - 12'd1) && (12'(cur_c_q) < c_lim);

  always_comb begin
    case (paddr[3:2])
      RegKernel: prdata = {29'd0, kernel_q};
      RegWidth:  prdata = {21'd0, width_q};
      RegHeight: prdata = {21'd0, height_q};
      default:   prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = (k_eff == KW'(1)) ? S_WR : S_RD;
      S_RD:   state_d = S_ACC;
      S_ACC:  state_d = (cnt_q + 1'b1 == k_eff) ? S_WR : S_RD;
      S_WR:   state_d = S_SUM;
      S_SUM:  if (idx_q == k_eff - 1'b1) state_d = S_CHK;
      S_CHK:  state_d = res_ok ? S_DIV : S_IDLE;
      S_DIV:  if (div_ctrl.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_re         = (state_q == S_RD);
    mem_we         = (state_q == S_WR);
    div_ctrl.start = (state_q == S_CHK) && res_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kernel_q    <= KW'(5);
      width_q     <= 11'd640;
      height_q    <= 11'd480;
      r_q         <= '0;
      c_q         <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && ((paddr[3:2] == RegKernel) || (paddr[3:2] == RegWidth) ||
                     (paddr[3:2] == RegHeight))) begin
        case (paddr[3:2])
          RegKernel: kernel_q <= pwdata[KW-1:0];
          RegWidth:  width_q  <= pwdata[10:0];
          RegHeight: height_q <= pwdata[10:0];
          default:   kernel_q <= kernel_q;
        endcase
        r_q    <= '0;
        c_q    <= '0;
        slot_q <= '0;
      end else if (in_acc) begin
        if (11'(c_q) + 11'd1 >= w_eff) begin
          c_q <= '0;
          if (11'(r_q) + 11'd1 >= ht_eff) begin
            r_q    <= '0;
            slot_q <= '0;
          end else begin
            r_q    <= r_q + 1'b1;
            slot_q <= (slot_q == SlotW'(LineRows - 1)) ? '0 : slot_q + 1'b1;
          end
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pix_q      <= {chan_c_i, chan_b_i, chan_a_i};
        cur_r_q    <= r_q;
        cur_c_q    <= c_q;
        cur_slot_q <= slot_q;
        rd_slot_q  <= slot_q;
        cnt_q      <= KW'(1);
        acc_q      <= {CsumW'(chan_c_i), CsumW'(chan_b_i), CsumW'(chan_a_i)};
      end
      S_RD: rd_slot_q <= slot_m1;
      S_ACC: begin
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= acc_q[i] + CsumW'(mem_rdata[8*i +: 8]);
        end
        cnt_q <= cnt_q + 1'b1;
      end
      S_WR: begin
        col_q[0] <= acc_q;
        for (int i = 1; i < MaxKernel; i++) begin
          col_q[i] <= col_q[i-1];
        end
        wsum_q <= '0;
        idx_q  <= '0;
      end
      S_SUM: begin
        for (int i = 0; i < 3; i++) begin
          wsum_q[i] <= wsum_q[i] + WsumW'(col_q[idx_q][i]);
        end
        idx_q <= idx_q + 1'b1;
      end
      S_CHK: begin
        res_row_q <= cur_r_q - ColW'(k_eff - 1'b1) + ColW'(h_eff);
        res_col_q <= cur_c_q - ColW'(k_eff - 1'b1) + ColW'(h_eff);
        res_end_q <= (12'(cur_r_q) + 12'd1 == r_lim) && (12'(cur_c_q) + 12'd1 == c_lim);
      end
      S_OUT: if (out_free) mean_q <= quot;
      default: idx_q <= idx_q;
    endcase
  end

  bmf_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({cur_slot_q, cur_c_q}),
    .wdata_i (pix_q),
    .re_i    (mem_re),
    .raddr_i ({slot_m1, cur_c_q}),
    .rdata_o (mem_rdata)
  );

  bmf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctrl.start),
    .num_i   (wsum_q),
    .den_i   (den),
    .done_o  (div_ctrl.done),
    .quot_o  (quot)
  );

  assign out_valid_o = out_valid_q;
  assign mean_a_o    = mean_q[0];
  assign mean_b_o    = mean_q[1];
  assign mean_c_o    = mean_q[2];

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_row_o   <= res_row_q;
      out_col_o   <= res_col_q;
      frame_end_o <= res_end_q;
    end
  end

endmodule

>>> rtl/bmf_line_mem.sv
// ----------------------------------------------------------------------------
// bmf_line_mem
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmf_line_mem
  import bmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [MemAw-1:0]  waddr_i,
  input  logic [PixW-1:0]   wdata_i,
  input  logic              re_i,
  input  logic [MemAw-1:0]  raddr_i,
  output logic [PixW-1:0]   rdata_o
);

  logic [PixW-1:0] mem [MemDepth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmf_div.sv
// ----------------------------------------------------------------------------
// bmf_div
// Three-lane restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmf_div
  import bmf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0][WsumW-1:0]   num_i,
  input  logic [DivW-1:0]         den_i,
  output logic                    done_o,
  output logic [2:0][7:0]         quot_o
);

  localparam int CntW = $clog2(WsumW + 1);

  logic [2:0][WsumW-1:0] num_q, num_d;
  logic [2:0][DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]       den_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;

  always_comb begin
    logic [DivW:0] trial;
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    trial  = '0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      for (int i = 0; i < 3; i++) begin
        trial = {rem_q[i][DivW-1:0], num_q[i][WsumW-1]};
        if (trial >= {1'b0, den_q}) begin
          rem_d[i] = trial - {1'b0, den_q};
          num_d[i] = {num_q[i][WsumW-2:0], 1'b1};
        end else begin
          rem_d[i] = trial;
          num_d[i] = {num_q[i][WsumW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WsumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  // quotient collects in the dividend register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot_o[i] = num_q[i][7:0];
    end
  end
  assign done_o = done_q;

endmodule

>>> rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks for the box mean filter.
// ----------------------------------------------------------------------------
module bmf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] mean_a_o,
  input logic [9:0] out_row_o
);

  // a pixel is worked on alone: the block stalls right after taking one
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no stall after beat");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mean_a_o) && $stable(out_row_o))
    else $error("stalled output changed");

endmodule

bind box_mean_filter_rgb bmf_checker u_bmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .mean_a_o    (mean_a_o),
  .out_row_o   (out_row_o)
);
